FILE: src/mkcc_pkg.sv
// ----------------------------------------------------------------------------
// Multi-key click classifier package
// Shared types, codes, register indexes and reset values for the per-key
// click, double-click and long-press classifier.
// ----------------------------------------------------------------------------
package mkcc_pkg;

  // Number of serviced keys and the address width of the per-key state memory.
  localparam int KEY_COUNT  = 16;
  localparam int KEY_ADDR_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  // Field widths fixed by the interface.
  localparam int KEY_W     = 4;
  localparam int CODE_W    = 4;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  // Per-key machine modes.
  typedef logic [1:0] key_mode_t;
  localparam key_mode_t MODE_IDLE    = 2'd0;
  localparam key_mode_t MODE_PRESSED = 2'd1;
  localparam key_mode_t MODE_WAIT    = 2'd2;

  // Reported event codes.
  typedef logic [CODE_W-1:0] event_code_t;
  localparam event_code_t EV_NOISE          = 4'd0;
  localparam event_code_t EV_SINGLE         = 4'd1;
  localparam event_code_t EV_DOUBLE         = 4'd2;
  localparam event_code_t EV_LONG           = 4'd3;
  localparam event_code_t EV_LATE_LONG      = 4'd4;
  localparam event_code_t EV_DOUBLE_TIMEOUT = 4'd5;
  localparam event_code_t EV_IDLE_RELEASE   = 4'd6;
  localparam event_code_t EV_WAIT_RELEASE   = 4'd7;
  localparam event_code_t EV_LONG_RELEASED  = 4'd8;
  localparam event_code_t EV_DOUBLE_PRESSED = 4'd9;
  localparam event_code_t EV_OTHER          = 4'd10;

  // Configuration register indexes.
  typedef logic [CFG_IDX_W-1:0] cfg_index_t;
  localparam cfg_index_t CFG_KEY_ENABLE_MASK      = 3'd0;
  localparam cfg_index_t CFG_NOISE_LIMIT_MS       = 3'd1;
  localparam cfg_index_t CFG_SHORT_PRESS_LIMIT_MS = 3'd2;
  localparam cfg_index_t CFG_LONG_PRESS_LIMIT_MS  = 3'd3;
  localparam cfg_index_t CFG_DOUBLE_WINDOW_MS     = 3'd4;
  localparam cfg_index_t CFG_LONG_CHECK_DELAY_MS  = 3'd5;
  localparam cfg_index_t CFG_DOUBLE_CHECK_DELAY_MS = 3'd6;

  // Configuration reset values.
  localparam logic [CFG_W-1:0] RST_KEY_ENABLE_MASK       = 16'd2047;
  localparam logic [CFG_W-1:0] RST_NOISE_LIMIT_MS        = 16'd20;
  localparam logic [CFG_W-1:0] RST_SHORT_PRESS_LIMIT_MS  = 16'd500;
  localparam logic [CFG_W-1:0] RST_LONG_PRESS_LIMIT_MS   = 16'd1500;
  localparam logic [CFG_W-1:0] RST_DOUBLE_WINDOW_MS      = 16'd600;
  localparam logic [CFG_W-1:0] RST_LONG_CHECK_DELAY_MS   = 16'd1500;
  localparam logic [CFG_W-1:0] RST_DOUBLE_CHECK_DELAY_MS = 16'd600;

  // One input request: a level change of one key, or a millisecond tick.
  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] key_id;
    logic             pressed;
  } in_item_t;

  // One reported event.
  typedef struct packed {
    logic [KEY_W-1:0] event_key;
    event_code_t      event_code;
    logic             last_event;
  } result_t;

  // One entry of the per-key state memory. All zeros is the reset state.
  typedef struct packed {
    key_mode_t         key_mode;
    logic              key_level;
    logic [TIME_W-1:0] press_stamp;
    logic [TIME_W-1:0] release_stamp;
    logic              long_armed;
    logic [TIME_W-1:0] long_deadline;
    logic              double_armed;
    logic [TIME_W-1:0] double_deadline;
  } key_entry_t;

  // A check delay of zero behaves as one millisecond.
  function automatic logic [CFG_W-1:0] delay_of(input logic [CFG_W-1:0] d);
    delay_of = (d == '0) ? CFG_W'(1) : d;
  endfunction

endpackage

FILE: src/multi_key_click_classifier_top.sv
// ----------------------------------------------------------------------------
// Multi-key click classifier
// A level change reads its key's entry, writes it back with its event and
// flushes the last event; a tick walks the per-key state memory one key a
// cycle while the output does not stall, then flushes. No new request is
// taken until the last event of the current one has been flushed.
// Reset: synchronous; all keys idle and released, deadlines disarmed, time
// zero, registers at their defaults. No clearing pass: valid bits per entry.
// ----------------------------------------------------------------------------
module multi_key_click_classifier_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  mkcc_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output mkcc_pkg::result_t          out_data,
  input  logic                       cfg_we,
  input  mkcc_pkg::cfg_index_t       cfg_index,
  input  logic [mkcc_pkg::CFG_W-1:0] cfg_wdata
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MOD   = 2'd1;
  localparam logic [1:0] S_EXTRA = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  localparam logic [mkcc_pkg::KEY_W-1:0] LAST_KEY =
    mkcc_pkg::KEY_W'(mkcc_pkg::KEY_COUNT - 1);

  // Configuration registers.
  logic [mkcc_pkg::CFG_W-1:0] key_enable_mask;
  logic [mkcc_pkg::CFG_W-1:0] noise_limit_ms;
  logic [mkcc_pkg::CFG_W-1:0] short_press_limit_ms;
  logic [mkcc_pkg::CFG_W-1:0] long_press_limit_ms;
  logic [mkcc_pkg::CFG_W-1:0] double_window_ms;
  logic [mkcc_pkg::CFG_W-1:0] long_check_delay_ms;
  logic [mkcc_pkg::CFG_W-1:0] double_check_delay_ms;

  // Control registers.
  logic [1:0]                  state;
  logic [1:0]                  state_next;
  logic                        is_tick;
  logic [mkcc_pkg::KEY_W-1:0]  cur_key;
  logic                        cur_level;
  logic [mkcc_pkg::TIME_W-1:0] now_ms;
  logic                        pend_valid;
  logic [mkcc_pkg::KEY_W-1:0]  pend_key;
  mkcc_pkg::event_code_t       pend_code;

  // State memory and its read port.
  mkcc_pkg::key_entry_t             key_mem [mkcc_pkg::KEY_COUNT];
  logic [mkcc_pkg::KEY_COUNT-1:0]   ent_valid;
  mkcc_pkg::key_entry_t             rd_entry;
  logic                             rd_valid;
  logic                             rd_en;
  logic [mkcc_pkg::KEY_ADDR_W-1:0]  rd_addr;
  logic                             wr_en;

  // Read-modify-write datapath.
  mkcc_pkg::key_entry_t        ent;
  mkcc_pkg::key_entry_t        upd;
  logic                        key_en;
  logic [mkcc_pkg::TIME_W-1:0] dur;
  logic [mkcc_pkg::TIME_W-1:0] gap;
  logic                        has_res;
  logic                        extra;
  mkcc_pkg::event_code_t       res_code;

  // Handshake helpers.
  logic in_take;
  logic out_free;
  logic push;
  logic stall;
  logic [mkcc_pkg::KEY_W-1:0] key_inc;

  assign in_ready = (state == S_IDLE);
  assign in_take  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign key_inc  = cur_key + 1'b1;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_enable_mask       <= mkcc_pkg::RST_KEY_ENABLE_MASK;
      noise_limit_ms        <= mkcc_pkg::RST_NOISE_LIMIT_MS;
      short_press_limit_ms  <= mkcc_pkg::RST_SHORT_PRESS_LIMIT_MS;
      long_press_limit_ms   <= mkcc_pkg::RST_LONG_PRESS_LIMIT_MS;
      double_window_ms      <= mkcc_pkg::RST_DOUBLE_WINDOW_MS;
      long_check_delay_ms   <= mkcc_pkg::RST_LONG_CHECK_DELAY_MS;
      double_check_delay_ms <= mkcc_pkg::RST_DOUBLE_CHECK_DELAY_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mkcc_pkg::CFG_KEY_ENABLE_MASK:       key_enable_mask       <= cfg_wdata;
        mkcc_pkg::CFG_NOISE_LIMIT_MS:        noise_limit_ms        <= cfg_wdata;
        mkcc_pkg::CFG_SHORT_PRESS_LIMIT_MS:  short_press_limit_ms  <= cfg_wdata;
        mkcc_pkg::CFG_LONG_PRESS_LIMIT_MS:   long_press_limit_ms   <= cfg_wdata;
        mkcc_pkg::CFG_DOUBLE_WINDOW_MS:      double_window_ms      <= cfg_wdata;
        mkcc_pkg::CFG_LONG_CHECK_DELAY_MS:   long_check_delay_ms   <= cfg_wdata;
        mkcc_pkg::CFG_DOUBLE_CHECK_DELAY_MS: double_check_delay_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next entry and event for the key whose state was just read.
  always_comb begin
    ent      = rd_valid ? rd_entry : '0;
    upd      = ent;
    has_res  = 1'b0;
    extra    = 1'b0;
    res_code = mkcc_pkg::EV_OTHER;
    key_en   = key_enable_mask[cur_key];
    dur      = now_ms - ent.press_stamp;
    gap      = now_ms - ent.release_stamp;
    if (is_tick) begin
      // Double-click deadline: confirm a single click or flag a held key.
      if (ent.double_armed && ent.double_deadline == now_ms) begin
        upd.double_armed = 1'b0;
        if (key_en && upd.key_mode == mkcc_pkg::MODE_WAIT) begin
          upd.key_mode = mkcc_pkg::MODE_IDLE;
          has_res      = 1'b1;
          res_code     = upd.key_level ? mkcc_pkg::EV_DOUBLE_PRESSED
                                       : mkcc_pkg::EV_SINGLE;
        end
      end
      // Long-press deadline: report a held key as a long press, a released one as long-released.
      if (ent.long_armed && ent.long_deadline == now_ms) begin
        upd.long_armed = 1'b0;
        if (key_en && upd.key_mode == mkcc_pkg::MODE_PRESSED) begin
          upd.key_mode = mkcc_pkg::MODE_IDLE;
          has_res      = 1'b1;
          res_code     = upd.key_level ? mkcc_pkg::EV_LONG
                                       : mkcc_pkg::EV_LONG_RELEASED;
        end
      end
    end else begin
      upd.key_level = cur_level;
      if (key_en) begin
        if (ent.key_mode == mkcc_pkg::MODE_IDLE && cur_level) begin
          // New press: stamp it and arm the held-key check.
          upd.press_stamp   = now_ms;
          upd.key_mode      = mkcc_pkg::MODE_PRESSED;
          upd.long_armed    = 1'b1;
          upd.long_deadline = now_ms +
            {{(mkcc_pkg::TIME_W-mkcc_pkg::CFG_W){1'b0}},
             mkcc_pkg::delay_of(long_check_delay_ms)};
        end else if (ent.key_mode == mkcc_pkg::MODE_PRESSED && !cur_level) begin
          // Release: classify the press by its length.
          upd.long_armed    = 1'b0;
          upd.release_stamp = now_ms;
          upd.key_mode      = mkcc_pkg::MODE_IDLE;
          has_res           = 1'b1;
          if (dur < {16'd0, noise_limit_ms}) begin
            res_code = mkcc_pkg::EV_NOISE;
          end else if (dur < {16'd0, short_press_limit_ms}) begin
            has_res             = 1'b0;
            upd.key_mode        = mkcc_pkg::MODE_WAIT;
            upd.double_armed    = 1'b1;
            upd.double_deadline = now_ms +
              {{(mkcc_pkg::TIME_W-mkcc_pkg::CFG_W){1'b0}},
               mkcc_pkg::delay_of(double_check_delay_ms)};
          end else if (dur < {16'd0, long_press_limit_ms}) begin
            res_code = mkcc_pkg::EV_SINGLE;
          end else begin
            res_code = mkcc_pkg::EV_LATE_LONG;
            extra    = 1'b1;
          end
        end else if (ent.key_mode == mkcc_pkg::MODE_WAIT && cur_level) begin
          // Second press: double click if it came inside the window.
          upd.double_armed = 1'b0;
          upd.key_mode     = mkcc_pkg::MODE_IDLE;
          has_res          = 1'b1;
          res_code         = (gap < {16'd0, double_window_ms})
                             ? mkcc_pkg::EV_DOUBLE : mkcc_pkg::EV_DOUBLE_TIMEOUT;
        end else begin
          // Any other transition is an error and returns the key to idle.
          upd.key_mode = mkcc_pkg::MODE_IDLE;
          has_res      = 1'b1;
          if (ent.key_mode == mkcc_pkg::MODE_IDLE && !cur_level) begin
            res_code = mkcc_pkg::EV_IDLE_RELEASE;
          end else if (ent.key_mode == mkcc_pkg::MODE_WAIT && !cur_level) begin
            res_code = mkcc_pkg::EV_WAIT_RELEASE;
          end else begin
            res_code = mkcc_pkg::EV_OTHER;
          end
        end
      end
    end
  end

  // Sequencer: read a key, write it back with its event, push a late long press's extra event, flush the last event.
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = cur_key[mkcc_pkg::KEY_ADDR_W-1:0];
    wr_en      = 1'b0;
    push       = 1'b0;
    stall      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          if (in_data.mode) begin
            rd_en      = 1'b1;
            rd_addr    = '0;
            state_next = S_MOD;
          end else if ({1'b0, in_data.key_id} < (mkcc_pkg::KEY_W+1)'(mkcc_pkg::KEY_COUNT)) begin
            rd_en      = 1'b1;
            rd_addr    = in_data.key_id[mkcc_pkg::KEY_ADDR_W-1:0];
            state_next = S_MOD;
          end
        end
      end
      S_MOD: begin
        stall = has_res && pend_valid && !out_free;
        if (!stall) begin
          wr_en = 1'b1;
          push  = has_res && pend_valid;
          if (is_tick) begin
            if (cur_key == LAST_KEY) begin
              state_next = S_FLUSH;
            end else begin
              rd_en   = 1'b1;
              rd_addr = key_inc[mkcc_pkg::KEY_ADDR_W-1:0];
            end
          end else begin
            state_next = extra ? S_EXTRA : S_FLUSH;
          end
        end
      end
      S_EXTRA: begin
        if (out_free) begin
          push       = 1'b1;
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          push       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers and the pending event.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      now_ms     <= '0;
      pend_valid <= 1'b0;
      ent_valid  <= '0;
    end else begin
      state <= state_next;
      if (in_take && in_data.mode) begin
        now_ms <= now_ms + 1'b1;
      end
      if (wr_en) begin
        ent_valid[cur_key[mkcc_pkg::KEY_ADDR_W-1:0]] <= 1'b1;
      end
      if (state == S_MOD && !stall && has_res) begin
        pend_valid <= 1'b1;
      end else if (state == S_FLUSH && push) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // Request fields, scan index and pending event payload.
  always_ff @(posedge clk) begin
    if (in_take) begin
      is_tick   <= in_data.mode;
      cur_key   <= in_data.mode ? '0 : in_data.key_id;
      cur_level <= in_data.pressed;
    end else if (state == S_MOD && !stall && is_tick && cur_key != LAST_KEY) begin
      cur_key <= key_inc;
    end
    if (state == S_MOD && !stall && has_res) begin
      pend_key  <= cur_key;
      pend_code <= res_code;
    end else if (state == S_EXTRA && push) begin
      pend_code <= mkcc_pkg::EV_LONG;
    end
  end

  // Per-key state memory, one read and one write port, registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[cur_key[mkcc_pkg::KEY_ADDR_W-1:0]] <= upd;
    end
    if (rd_en) begin
      rd_entry <= key_mem[rd_addr];
      rd_valid <= ent_valid[rd_addr];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data.event_key  <= pend_key;
      out_data.event_code <= pend_code;
      out_data.last_event <= (state == S_FLUSH);
    end
  end

endmodule

FILE: src/mkcc_checker.sv
// ----------------------------------------------------------------------------
// Multi-key click classifier checker
// Port-level checks on the classifier, attached to the top level by bind.
// ----------------------------------------------------------------------------
module mkcc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input mkcc_pkg::in_item_t         in_data,
  input logic                       out_valid,
  input logic                       out_ready,
  input mkcc_pkg::result_t          out_data
);

  // A stalled event holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled event changed");

  // A tick request always occupies the block on the following cycle.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.mode |=> !in_ready)
    else $error("block took a request during a tick scan");

  // Reported codes stay within the defined set.
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.event_code <= mkcc_pkg::EV_OTHER)
    else $error("undefined event code");

  // Events belong to existing keys.
  a_key_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {1'b0, out_data.event_key} <
                  (mkcc_pkg::KEY_W+1)'(mkcc_pkg::KEY_COUNT))
    else $error("event for a key that does not exist");

  // Nothing is reported right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("event present after reset");

endmodule

bind multi_key_click_classifier_top mkcc_checker u_mkcc_checker (.*);

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Multi-key click classifier testbench
// Sends key level changes and millisecond ticks through the request channel,
// predicts every reported event with a per-key model of the click machines,
// and checks each event in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mkcc_pkg::*;

  // Request kinds on the mode field.
  localparam logic REQ_LEVEL = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // Cycles a tick needs to walk all keys, with margin for output stalls.
  localparam int SETTLE_CYCLES = 40;
  // Cycles without any handshake before the run is declared hung.
  localparam int QUIET_LIMIT   = 4000;
  localparam int PHASE_COUNT   = 8;
  localparam int PHASE_ITEMS   = 35;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  result_t          out_data;
  logic             cfg_we    = 1'b0;
  cfg_index_t       cfg_index = CFG_KEY_ENABLE_MASK;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // When set, neither side inserts idle cycles.
  bit steady_run = 1'b0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  // Model of the block: register copies and per-key machine state.
  logic [CFG_W-1:0]  setting       [0:6];
  key_mode_t         key_state     [KEY_COUNT];
  logic              key_down      [KEY_COUNT];
  logic [TIME_W-1:0] pressed_at    [KEY_COUNT];
  logic [TIME_W-1:0] released_at   [KEY_COUNT];
  logic              hold_armed    [KEY_COUNT];
  logic [TIME_W-1:0] hold_due      [KEY_COUNT];
  logic              confirm_armed [KEY_COUNT];
  logic [TIME_W-1:0] confirm_due   [KEY_COUNT];
  logic [TIME_W-1:0] clock_ms;

  // Events raised by the request under prediction, and all events still owed.
  result_t step_events[$];
  result_t expected_events[$];

  multi_key_click_classifier_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Click machine model
  // ---------------------------------------------------------------------------

  function automatic void clear_model();
    setting[CFG_KEY_ENABLE_MASK]       = RST_KEY_ENABLE_MASK;
    setting[CFG_NOISE_LIMIT_MS]        = RST_NOISE_LIMIT_MS;
    setting[CFG_SHORT_PRESS_LIMIT_MS]  = RST_SHORT_PRESS_LIMIT_MS;
    setting[CFG_LONG_PRESS_LIMIT_MS]   = RST_LONG_PRESS_LIMIT_MS;
    setting[CFG_DOUBLE_WINDOW_MS]      = RST_DOUBLE_WINDOW_MS;
    setting[CFG_LONG_CHECK_DELAY_MS]   = RST_LONG_CHECK_DELAY_MS;
    setting[CFG_DOUBLE_CHECK_DELAY_MS] = RST_DOUBLE_CHECK_DELAY_MS;
    for (int i = 0; i < KEY_COUNT; i++) begin
      key_state[i]     = MODE_IDLE;
      key_down[i]      = 1'b0;
      pressed_at[i]    = '0;
      released_at[i]   = '0;
      hold_armed[i]    = 1'b0;
      hold_due[i]      = '0;
      confirm_armed[i] = 1'b0;
      confirm_due[i]   = '0;
    end
    clock_ms = '0;
  endfunction

  // A programmed delay of zero still waits one millisecond.
  function automatic logic [TIME_W-1:0] at_least_one_ms(input logic [CFG_W-1:0] d);
    return (d == 0) ? TIME_W'(1) : TIME_W'(d);
  endfunction

  function automatic void add_event(input int k, input event_code_t code);
    result_t ev;
    ev.event_key  = KEY_W'(k);
    ev.event_code = code;
    ev.last_event = 1'b0;
    step_events.push_back(ev);
  endfunction

  // Deadline scan of one tick, keys in ascending order, confirm before hold.
  function automatic void scan_deadlines();
    clock_ms = clock_ms + 1;
    for (int i = 0; i < KEY_COUNT; i++) begin
      if (confirm_armed[i] && confirm_due[i] == clock_ms) begin
        confirm_armed[i] = 1'b0;
        if (setting[CFG_KEY_ENABLE_MASK][i] && key_state[i] == MODE_WAIT) begin
          key_state[i] = MODE_IDLE;
          add_event(i, key_down[i] ? EV_DOUBLE_PRESSED : EV_SINGLE);
        end
      end
      if (hold_armed[i] && hold_due[i] == clock_ms) begin
        hold_armed[i] = 1'b0;
        if (setting[CFG_KEY_ENABLE_MASK][i] && key_state[i] == MODE_PRESSED) begin
          key_state[i] = MODE_IDLE;
          add_event(i, key_down[i] ? EV_LONG : EV_LONG_RELEASED);
        end
      end
    end
  endfunction

  // Level change of one key: the level is always recorded, the machine only
  // moves while the key is enabled.
  function automatic void move_key(input int k, input logic lvl);
    key_mode_t   prior;
    logic [TIME_W-1:0] held_ms;
    prior = key_state[k];
    key_down[k] = lvl;
    if (!setting[CFG_KEY_ENABLE_MASK][k]) return;
    if (prior == MODE_IDLE && lvl) begin
      pressed_at[k] = clock_ms;
      key_state[k]  = MODE_PRESSED;
      hold_armed[k] = 1'b1;
      hold_due[k]   = clock_ms + at_least_one_ms(setting[CFG_LONG_CHECK_DELAY_MS]);
    end else if (prior == MODE_PRESSED && !lvl) begin
      hold_armed[k]  = 1'b0;
      released_at[k] = clock_ms;
      held_ms        = clock_ms - pressed_at[k];
      key_state[k]   = MODE_IDLE;
      if (held_ms < setting[CFG_NOISE_LIMIT_MS]) begin
        add_event(k, EV_NOISE);
      end else if (held_ms < setting[CFG_SHORT_PRESS_LIMIT_MS]) begin
        key_state[k]     = MODE_WAIT;
        confirm_armed[k] = 1'b1;
        confirm_due[k]   = clock_ms + at_least_one_ms(setting[CFG_DOUBLE_CHECK_DELAY_MS]);
      end else if (held_ms < setting[CFG_LONG_PRESS_LIMIT_MS]) begin
        add_event(k, EV_SINGLE);
      end else begin
        add_event(k, EV_LATE_LONG);
        add_event(k, EV_LONG);
      end
    end else if (prior == MODE_WAIT && lvl) begin
      confirm_armed[k] = 1'b0;
      key_state[k]     = MODE_IDLE;
      if (clock_ms - released_at[k] < setting[CFG_DOUBLE_WINDOW_MS])
        add_event(k, EV_DOUBLE);
      else
        add_event(k, EV_DOUBLE_TIMEOUT);
    end else begin
      // Release while idle or waiting, or a second press while held.
      key_state[k] = MODE_IDLE;
      if (prior == MODE_IDLE)
        add_event(k, EV_IDLE_RELEASE);
      else if (prior == MODE_WAIT)
        add_event(k, EV_WAIT_RELEASE);
      else
        add_event(k, EV_OTHER);
    end
  endfunction

  // Work out the events of one accepted request and queue them in order.
  function automatic void predict_request(input in_item_t req);
    step_events.delete();
    if (req.mode == REQ_TICK)
      scan_deadlines();
    else
      move_key(int'(req.key_id), req.pressed);
    if (step_events.size() > 0)
      step_events[step_events.size() - 1].last_event = 1'b1;
    foreach (step_events[i])
      expected_events.push_back(step_events[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Offer one request; valid stays up after acceptance until the next change.
  task automatic send_request(input in_item_t req);
    @(negedge clk);
    while (!steady_run && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(req);
  endtask

  task automatic level_change(input int k, input logic lvl);
    in_item_t req;
    req.mode    = REQ_LEVEL;
    req.key_id  = KEY_W'(k);
    req.pressed = lvl;
    send_request(req);
  endtask

  // The key and level fields are don't-care on a tick, so fill them at random.
  task automatic ms_tick();
    in_item_t req;
    req.mode    = REQ_TICK;
    req.key_id  = KEY_W'($urandom);
    req.pressed = 1'($urandom);
    send_request(req);
  endtask

  // Stop requesting, wait for every owed event, then for a tick to finish.
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write enable stays high across consecutive writes; the caller lowers it.
  task automatic put_register(input cfg_index_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    setting[idx] = val;
  endtask

  task automatic program_settings(input logic [CFG_W-1:0] mask, noise_lim, click_lim,
                                  hold_lim, gap_lim, hold_chk, click_chk);
    settle_block();
    put_register(CFG_KEY_ENABLE_MASK, mask);
    put_register(CFG_NOISE_LIMIT_MS, noise_lim);
    put_register(CFG_SHORT_PRESS_LIMIT_MS, click_lim);
    put_register(CFG_LONG_PRESS_LIMIT_MS, hold_lim);
    put_register(CFG_DOUBLE_WINDOW_MS, gap_lim);
    put_register(CFG_LONG_CHECK_DELAY_MS, hold_chk);
    put_register(CFG_DOUBLE_CHECK_DELAY_MS, click_chk);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side backpressure.
  always @(negedge clk) begin
    out_ready <= steady_run || ($urandom_range(0, 99) >= 6);
  end

  // ---------------------------------------------------------------------------
  // Event checker and watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected event: expected none, actual key %0d code %0d last %0b",
                 $time, out_data.event_key, out_data.event_code, out_data.last_event);
      end else begin
        want = expected_events.pop_front();
        if (out_data.event_key !== want.event_key) begin
          mismatch_count++;
          $display("%0t: event_key mismatch: expected %0d, actual %0d",
                   $time, want.event_key, out_data.event_key);
        end
        if (out_data.event_code !== want.event_code) begin
          mismatch_count++;
          $display("%0t: event_code mismatch (key %0d): expected %0d, actual %0d",
                   $time, want.event_key, want.event_code, out_data.event_code);
        end
        if (out_data.last_event !== want.last_event) begin
          mismatch_count++;
          $display("%0t: last_event mismatch (key %0d): expected %0b, actual %0b",
                   $time, want.event_key, want.last_event, out_data.last_event);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d events still owed",
               $time, QUIET_LIMIT, expected_events.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: keys 11 to 15 are off, and a zero-length press is noise.
  task automatic test_default_settings();
    level_change(15, 1'b1);
    level_change(15, 1'b0);
    level_change(0, 1'b1);
    level_change(0, 1'b0);
    level_change(0, 1'b0);
  endtask

  // Every release class with tiny limits, many keys sharing the same ticks.
  task automatic test_release_classes();
    program_settings(16'hFFFF, 16'd1, 16'd2, 16'd3, 16'd1, 16'd5, 16'd2);
    level_change(0, 1'b1);
    level_change(0, 1'b0);
    level_change(1, 1'b1);
    level_change(2, 1'b1);
    level_change(3, 1'b1);
    level_change(4, 1'b1);
    level_change(7, 1'b1);
    level_change(8, 1'b1);
    level_change(9, 1'b1);
    // A second press while held is an error.
    level_change(5, 1'b1);
    level_change(5, 1'b1);
    ms_tick();
    // One millisecond presses open the double click wait.
    level_change(1, 1'b0);
    level_change(1, 1'b1);
    level_change(7, 1'b0);
    level_change(8, 1'b0);
    level_change(8, 1'b0);
    level_change(9, 1'b0);
    ms_tick();
    // Second press outside the window, a plain single click, a stray release.
    level_change(9, 1'b1);
    level_change(2, 1'b0);
    level_change(6, 1'b0);
    ms_tick();
    level_change(3, 1'b0);
    // The held key's check fires as a long press.
    ms_tick();
    ms_tick();
  endtask

  // Levels that change while a key is masked show up when its check fires.
  task automatic test_masked_levels();
    program_settings(16'hFFFF, 16'd1, 16'd2, 16'd3, 16'd1, 16'd5, 16'd2);
    level_change(10, 1'b1);
    level_change(11, 1'b1);
    level_change(12, 1'b1);
    ms_tick();
    level_change(11, 1'b0);
    program_settings(16'hE3FF, 16'd1, 16'd2, 16'd3, 16'd1, 16'd5, 16'd2);
    level_change(10, 1'b0);
    level_change(11, 1'b1);
    // Key 12 stays off so its hold check lapses without an event.
    program_settings(16'hEFFF, 16'd1, 16'd2, 16'd3, 16'd1, 16'd5, 16'd2);
    ms_tick();
    ms_tick();
    ms_tick();
    ms_tick();
  endtask

  // All limits at zero and at full scale; zero check delays act as one.
  task automatic test_extreme_settings();
    program_settings(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    level_change(13, 1'b1);
    level_change(13, 1'b0);
    level_change(14, 1'b1);
    ms_tick();
    level_change(14, 1'b0);
    program_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF);
    level_change(13, 1'b1);
    ms_tick();
    level_change(13, 1'b0);
  endtask

  // Phases of random settings; within a phase, mostly alternating levels on a
  // small group of keys mixed with ticks, plus repeated levels as noise.
  task automatic test_random_traffic();
    int unsigned noise_lim;
    int unsigned click_lim;
    int unsigned hold_lim;
    int unsigned group;
    int          k;
    logic        lvl;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      steady_run = 1'b0;
      noise_lim  = $urandom_range(0, 3);
      click_lim  = noise_lim + $urandom_range(0, 5);
      hold_lim   = click_lim + $urandom_range(0, 6);
      program_settings(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'hFFFF,
                       16'(noise_lim), 16'(click_lim), 16'(hold_lim),
                       16'($urandom_range(0, 8)), 16'($urandom_range(0, 14)),
                       16'($urandom_range(0, 9)));
      steady_run = (phase == 2);
      group      = $urandom_range(0, KEY_COUNT - 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 40) begin
          ms_tick();
        end else begin
          if ($urandom_range(0, 99) < 70)
            k = group + $urandom_range(0, 3);
          else
            k = $urandom_range(0, KEY_COUNT - 1);
          lvl = ($urandom_range(0, 99) < 85) ? !key_down[k] : key_down[k];
          level_change(k, lvl);
        end
      end
    end
    steady_run = 1'b0;
  endtask

  initial begin
    clear_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_settings();
    test_release_classes();
    test_masked_levels();
    test_extreme_settings();
    test_random_traffic();

    settle_block();
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
